// ===== rtl/urmg_pkg.sv =====
// Shared constants, types and saturating arithmetic for the undistort remap map generator.
package urmg_pkg;

  // Fixed-point and geometry constants.
  localparam int FRAC_BITS   = 28;
  localparam int MAX_DIM     = 4096;
  localparam int STORE_WORDS = 11;
  localparam int INT_BITS    = 31 - FRAC_BITS;
  localparam int QW          = 31;
  localparam int PW          = 45;
  localparam int SW          = 47;
  localparam int DW          = SW;
  localparam int RW          = DW + INT_BITS;
  localparam int DIST_STAGES = 13;

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [23:0] S24_MAX = 24'sh7f_ffff;
  localparam logic signed [23:0] S24_MIN = 24'sh80_0000;
  localparam logic signed [31:0] Q_ONE   = 32'sd1 <<< FRAC_BITS;

  // Item modes.
  localparam logic MODE_COEF  = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_FOCAL_X  = 3'd0,
    REG_FOCAL_Y  = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_K1       = 3'd4,
    REG_K2       = 3'd5,
    REG_K3       = 3'd6,
    REG_RESERVED = 3'd7
  } cfg_reg_t;

  // A saturated value with its overflow flag.
  typedef struct packed {
    logic               ovf;
    logic signed [31:0] val;
  } q_t;

  // Per-item data that rides alongside the divider.
  typedef struct packed {
    logic signed [31:0] m9;
    logic signed [31:0] m10;
    logic               zero;
    logic               flag;
  } side_t;

  // One stage of the divider.
  typedef struct packed {
    logic [RW-1:0] rx;
    logic [RW-1:0] ry;
    logic [QW-1:0] qx;
    logic [QW-1:0] qy;
    logic [DW-1:0] ud;
    logic          nx;
    logic          ny;
    logic          ox;
    logic          oy;
    side_t         side;
  } dv_t;

  // One stage of the distortion pipeline.
  typedef struct packed {
    logic signed [31:0] xn;
    logic signed [31:0] yn;
    logic signed [31:0] m9;
    logic signed [31:0] m10;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] r2;
    logic signed [31:0] xy2;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] t;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [63:0] p0;
    logic signed [63:0] p1;
    logic signed [63:0] p2;
    logic signed [63:0] p3;
    logic signed [23:0] mx;
    logic signed [23:0] my;
    logic               zero;
    logic               flag;
  } dst_t;

  // Clamp a 33-bit sum to 32 bits.
  function automatic q_t sat33(input logic signed [32:0] s);
    q_t r;
    r.ovf = s[32] != s[31];
    r.val = r.ovf ? (s[32] ? S32_MIN : S32_MAX) : s[31:0];
    return r;
  endfunction

  // Saturating addition.
  function automatic q_t sat_add(input logic signed [31:0] a, input logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    return sat33(s);
  endfunction

  // Floor-scaled product clamped to 32 bits.
  function automatic q_t sat_mul(input logic signed [63:0] p);
    logic signed [63:0] s;
    q_t r;
    s = p >>> FRAC_BITS;
    r.ovf = !((&s[63:31]) || !(|s[63:31]));
    r.val = r.ovf ? (s[63] ? S32_MIN : S32_MAX) : s[31:0];
    return r;
  endfunction

  // Full signed 32 by 32 product.
  function automatic logic signed [63:0] mul32(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] r;
    r = a * b;
    return r;
  endfunction

endpackage

// ===== rtl/urmg_if.sv =====
// Valid/ready channel interfaces for pixel and coefficient words in and map words out.
interface urmg_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [3:0]         word_index;
  logic signed [31:0] word_value;
  logic [11:0]        pixel_col;
  logic [11:0]        pixel_row;

  modport source (output valid, mode, word_index, word_value, pixel_col, pixel_row,
                  input ready);
  modport sink (input valid, mode, word_index, word_value, pixel_col, pixel_row,
                output ready);
endinterface

interface urmg_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] map_x;
  logic signed [23:0] map_y;
  logic               saturated;

  modport source (output valid, map_x, map_y, saturated, input ready);
  modport sink (input valid, map_x, map_y, saturated, output ready);
endinterface

// ===== rtl/urmg_div.sv =====
// Pipelined restoring divider producing both normalised coordinates from one divisor.
module urmg_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      in_vld,
  input  logic signed [urmg_pkg::SW-1:0] num_x,
  input  logic signed [urmg_pkg::SW-1:0] num_y,
  input  logic signed [urmg_pkg::SW-1:0] den,
  input  urmg_pkg::side_t           side_in,
  output logic                      out_vld,
  output logic signed [31:0]        xn,
  output logic signed [31:0]        yn,
  output urmg_pkg::side_t           side_out
);

  localparam int QW = urmg_pkg::QW;
  localparam int RW = urmg_pkg::RW;
  localparam int DW = urmg_pkg::DW;
  localparam int IB = urmg_pkg::INT_BITS;

  urmg_pkg::dv_t   st_r  [0:QW];
  urmg_pkg::dv_t   d_nxt [0:QW];
  logic [QW+1:0]   vld_r;
  logic signed [31:0] xn_r, yn_r, xn_nxt, yn_nxt;
  urmg_pkg::side_t side_r, side_nxt;

  // Entry stage: magnitudes, quotient signs and zero divisor detect.
  always_comb begin
    d_nxt[0]      = '0;
    d_nxt[0].rx   = RW'(num_x[urmg_pkg::SW-1] ? DW'(-num_x) : DW'(num_x));
    d_nxt[0].ry   = RW'(num_y[urmg_pkg::SW-1] ? DW'(-num_y) : DW'(num_y));
    d_nxt[0].ud   = den[urmg_pkg::SW-1] ? DW'(-den) : DW'(den);
    d_nxt[0].nx   = num_x[urmg_pkg::SW-1] ^ den[urmg_pkg::SW-1];
    d_nxt[0].ny   = num_y[urmg_pkg::SW-1] ^ den[urmg_pkg::SW-1];
    d_nxt[0].side = side_in;
    d_nxt[0].side.zero = (den == '0);
  end

  // One quotient bit per stage: integer bits first, then fraction bits.
  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int SH  = (k < IB) ? (IB - 1 - k) : 0;
    localparam bit PRE = (k >= IB);
    always_comb begin
      urmg_pkg::dv_t p;
      urmg_pkg::dv_t n;
      logic [RW-1:0] rsx, rsy, dsh;
      p   = st_r[k];
      n   = p;
      dsh = RW'(p.ud) << SH;
      rsx = PRE ? (p.rx << 1) : p.rx;
      rsy = PRE ? (p.ry << 1) : p.ry;
      if (k == 0) begin
        n.ox = p.rx >= (RW'(p.ud) << IB);
        n.oy = p.ry >= (RW'(p.ud) << IB);
      end
      if (rsx >= dsh) begin
        n.rx = rsx - dsh;
        n.qx = {p.qx[QW-2:0], 1'b1};
      end else begin
        n.rx = rsx;
        n.qx = {p.qx[QW-2:0], 1'b0};
      end
      if (rsy >= dsh) begin
        n.ry = rsy - dsh;
        n.qy = {p.qy[QW-2:0], 1'b1};
      end else begin
        n.ry = rsy;
        n.qy = {p.qy[QW-2:0], 1'b0};
      end
      d_nxt[k+1] = n;
    end
  end

  // Sign and clamp of the finished quotients.
  always_comb begin
    urmg_pkg::dv_t p;
    logic signed [31:0] qx, qy;
    p  = st_r[QW];
    qx = $signed({1'b0, p.qx});
    qy = $signed({1'b0, p.qy});
    xn_nxt = p.ox ? (p.nx ? urmg_pkg::S32_MIN : urmg_pkg::S32_MAX) : (p.nx ? -qx : qx);
    yn_nxt = p.oy ? (p.ny ? urmg_pkg::S32_MIN : urmg_pkg::S32_MAX) : (p.ny ? -qy : qy);
    side_nxt = p.side;
    side_nxt.flag = p.side.flag | p.ox | p.oy;
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[QW:0], in_vld};
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      st_r   <= d_nxt;
      xn_r   <= xn_nxt;
      yn_r   <= yn_nxt;
      side_r <= side_nxt;
    end
  end

  assign out_vld  = vld_r[QW+1];
  assign xn       = xn_r;
  assign yn       = yn_r;
  assign side_out = side_r;

endmodule

// ===== rtl/urmg_dist.sv =====
// Distortion polynomial, focal scaling and output clamp as a register pipeline.
module urmg_dist (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_vld,
  input  logic signed [31:0]  xn,
  input  logic signed [31:0]  yn,
  input  urmg_pkg::side_t     side,
  input  logic signed [31:0]  k1,
  input  logic signed [31:0]  k2,
  input  logic signed [31:0]  k3,
  input  logic [23:0]         focal_x,
  input  logic [23:0]         focal_y,
  input  logic [23:0]         center_x,
  input  logic [23:0]         center_y,
  output logic                out_vld,
  output logic signed [23:0]  map_x,
  output logic signed [23:0]  map_y,
  output logic                sat
);

  localparam int N = urmg_pkg::DIST_STAGES;

  urmg_pkg::dst_t st_r  [1:N];
  urmg_pkg::dst_t s_nxt [1:N];
  logic [N:1]     vld_r;

  // Focal product.
  function automatic logic signed [63:0] mul_focal(input logic [23:0] f,
                                                  input logic signed [31:0] d);
    logic signed [24:0] fs;
    logic signed [63:0] r;
    fs = $signed({1'b0, f});
    r  = fs * d;
    return r;
  endfunction

  // Scale back, add the centre and clamp to Q16.8.
  function automatic logic [24:0] map_fin(input logic signed [63:0] p, input logic [23:0] c);
    logic signed [63:0] sh;
    logic signed [29:0] mw;
    logic               ovf;
    logic signed [23:0] m;
    sh  = p >>> urmg_pkg::FRAC_BITS;
    mw  = 30'(sh) + $signed({6'b0, c});
    ovf = !((&mw[29:23]) || !(|mw[29:23]));
    m   = ovf ? (mw[29] ? urmg_pkg::S24_MIN : urmg_pkg::S24_MAX) : mw[23:0];
    return {ovf, m};
  endfunction

  always_comb begin
    urmg_pkg::dst_t p;
    urmg_pkg::q_t   a, b, c, d, e;
    logic [24:0]    fx, fy;

    // Stage 1: squares and doublings.
    s_nxt[1]      = '0;
    s_nxt[1].xn   = xn;
    s_nxt[1].yn   = yn;
    s_nxt[1].m9   = side.m9;
    s_nxt[1].m10  = side.m10;
    s_nxt[1].zero = side.zero;
    a = urmg_pkg::sat_add(xn, xn);
    b = urmg_pkg::sat_add(yn, yn);
    s_nxt[1].dx   = a.val;
    s_nxt[1].dy   = b.val;
    s_nxt[1].p0   = urmg_pkg::mul32(xn, xn);
    s_nxt[1].p1   = urmg_pkg::mul32(yn, yn);
    s_nxt[1].flag = side.flag | a.ovf | b.ovf;

    // Stage 2: radius squared and the cross products.
    p = st_r[1];
    s_nxt[2] = p;
    a = urmg_pkg::sat_mul(p.p0);
    b = urmg_pkg::sat_mul(p.p1);
    c = urmg_pkg::sat_add(a.val, b.val);
    s_nxt[2].r2   = c.val;
    s_nxt[2].p0   = urmg_pkg::mul32(p.dx, p.yn);
    s_nxt[2].p1   = urmg_pkg::mul32(p.dx, p.xn);
    s_nxt[2].p2   = urmg_pkg::mul32(p.dy, p.yn);
    s_nxt[2].flag = p.flag | a.ovf | b.ovf | c.ovf;

    // Stage 3: tangential terms and the innermost radial product.
    p = st_r[2];
    s_nxt[3] = p;
    a = urmg_pkg::sat_mul(p.p0);
    b = urmg_pkg::sat_mul(p.p1);
    c = urmg_pkg::sat_add(p.r2, b.val);
    d = urmg_pkg::sat_mul(p.p2);
    e = urmg_pkg::sat_add(p.r2, d.val);
    s_nxt[3].xy2  = a.val;
    s_nxt[3].sx   = c.val;
    s_nxt[3].sy   = e.val;
    s_nxt[3].p3   = urmg_pkg::mul32(p.r2, k3);
    s_nxt[3].flag = p.flag | a.ovf | b.ovf | c.ovf | d.ovf | e.ovf;

    // Stage 4: first Horner step and the tangential coefficient products.
    p = st_r[3];
    s_nxt[4] = p;
    a = urmg_pkg::sat_mul(p.p3);
    b = urmg_pkg::sat_add(k2, a.val);
    s_nxt[4].t    = b.val;
    s_nxt[4].p0   = urmg_pkg::mul32(p.m9, p.xy2);
    s_nxt[4].p1   = urmg_pkg::mul32(p.m10, p.xy2);
    s_nxt[4].p2   = urmg_pkg::mul32(p.m10, p.sx);
    s_nxt[4].p3   = urmg_pkg::mul32(p.m9, p.sy);
    s_nxt[4].flag = p.flag | a.ovf | b.ovf;

    // Stage 5: scale the tangential products, start the second Horner step.
    p = st_r[4];
    s_nxt[5] = p;
    a = urmg_pkg::sat_mul(p.p0);
    b = urmg_pkg::sat_mul(p.p1);
    c = urmg_pkg::sat_mul(p.p2);
    d = urmg_pkg::sat_mul(p.p3);
    s_nxt[5].ax   = a.val;
    s_nxt[5].ay   = b.val;
    s_nxt[5].bx   = c.val;
    s_nxt[5].by   = d.val;
    s_nxt[5].p0   = urmg_pkg::mul32(p.r2, p.t);
    s_nxt[5].flag = p.flag | a.ovf | b.ovf | c.ovf | d.ovf;

    // Stage 6: second Horner step.
    p = st_r[5];
    s_nxt[6] = p;
    a = urmg_pkg::sat_mul(p.p0);
    b = urmg_pkg::sat_add(k1, a.val);
    s_nxt[6].t    = b.val;
    s_nxt[6].flag = p.flag | a.ovf | b.ovf;

    // Stage 7: last radial product.
    p = st_r[6];
    s_nxt[7] = p;
    s_nxt[7].p0 = urmg_pkg::mul32(p.r2, p.t);

    // Stage 8: radial factor, held in t from here on.
    p = st_r[7];
    s_nxt[8] = p;
    a = urmg_pkg::sat_mul(p.p0);
    b = urmg_pkg::sat_add(urmg_pkg::Q_ONE, a.val);
    s_nxt[8].t    = b.val;
    s_nxt[8].flag = p.flag | a.ovf | b.ovf;

    // Stage 9: apply the radial factor.
    p = st_r[8];
    s_nxt[9] = p;
    s_nxt[9].p0 = urmg_pkg::mul32(p.xn, p.t);
    s_nxt[9].p1 = urmg_pkg::mul32(p.yn, p.t);

    // Stage 10: add the first tangential term.
    p = st_r[9];
    s_nxt[10] = p;
    a = urmg_pkg::sat_mul(p.p0);
    b = urmg_pkg::sat_add(a.val, p.ax);
    c = urmg_pkg::sat_mul(p.p1);
    d = urmg_pkg::sat_add(c.val, p.ay);
    s_nxt[10].ex   = b.val;
    s_nxt[10].ey   = d.val;
    s_nxt[10].flag = p.flag | a.ovf | b.ovf | c.ovf | d.ovf;

    // Stage 11: add the second tangential term.
    p = st_r[10];
    s_nxt[11] = p;
    a = urmg_pkg::sat_add(p.ex, p.bx);
    b = urmg_pkg::sat_add(p.ey, p.by);
    s_nxt[11].ex   = a.val;
    s_nxt[11].ey   = b.val;
    s_nxt[11].flag = p.flag | a.ovf | b.ovf;

    // Stage 12: focal scaling.
    p = st_r[11];
    s_nxt[12] = p;
    s_nxt[12].p0 = mul_focal(focal_x, p.ex);
    s_nxt[12].p1 = mul_focal(focal_y, p.ey);

    // Stage 13: centre offset, clamp, zero divisor override.
    p = st_r[12];
    s_nxt[13] = p;
    fx = map_fin(p.p0, center_x);
    fy = map_fin(p.p1, center_y);
    if (p.zero) begin
      s_nxt[13].mx   = urmg_pkg::S24_MAX;
      s_nxt[13].my   = urmg_pkg::S24_MAX;
      s_nxt[13].flag = 1'b1;
    end else begin
      s_nxt[13].mx   = fx[23:0];
      s_nxt[13].my   = fy[23:0];
      s_nxt[13].flag = p.flag | fx[24] | fy[24];
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[N-1:1], in_vld};
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      st_r <= s_nxt;
    end
  end

  assign out_vld = vld_r[N];
  assign map_x   = st_r[N].mx;
  assign map_y   = st_r[N].my;
  assign sat     = st_r[N].flag;

  // A word reaching the last stage must have come from the one before it.
  a_advance : assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> vld_r[N] == $past(vld_r[N-1]))
    else $error("output valid does not follow the previous stage");

  // A held pipeline keeps its output word.
  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r) && $stable(st_r[N].mx) && $stable(st_r[N].my))
    else $error("pipeline moved while stalled");

  // A zero divisor always yields the clamped coordinates with the flag.
  a_zero : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[N] && st_r[N].zero |->
      st_r[N].flag && st_r[N].mx == urmg_pkg::S24_MAX && st_r[N].my == urmg_pkg::S24_MAX)
    else $error("zero divisor not reported");

endmodule

// ===== rtl/undistort_remap_map_generator.sv =====
// Top level of the undistort remap map generator.
// Pixel and coefficient words arrive on in_ch (valid/ready). A coefficient word
// (mode 0) writes one entry of the eleven-word store: nine matrix words and the
// two tangential coefficients; it gives no output word. A pixel word (mode 1)
// gives one out_ch word with map_x, map_y (signed Q16.8) and a saturated flag.
// The user must write configuration registers through cfg_we/cfg_index/cfg_wdata
// only while the block holds no word in flight; the block does not enforce it.
// Throughput is one word per clock while out_ch is not stalled. A pixel passes 48
// register stages: two stages of matrix products and sums, 33 in the divider
// (one quotient bit per stage for 31 bits, plus entry and sign stages) and 13
// in the distortion and scaling pipeline.
// The whole pipeline advances together; when out_ch holds a word that is not
// taken, in_ch ready drops and every stage keeps its contents, so nothing is
// lost or repeated. Bubbles keep moving while the output register is empty.
// Reset clears all valid bits, the coefficient store and loads the default
// focal lengths and principal point.
module undistort_remap_map_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  urmg_in_if.sink     in_ch,
  urmg_out_if.source  out_ch
);

  localparam int SW = urmg_pkg::SW;
  localparam int PW = urmg_pkg::PW;

  logic [23:0]        focal_x_r, focal_y_r, center_x_r, center_y_r;
  logic signed [31:0] k1_r, k2_r, k3_r;
  logic signed [31:0] coef_r [0:urmg_pkg::STORE_WORDS-1];

  logic               adv, in_acc;
  logic               dist_vld;

  logic [11:0]        col_c, row_c;
  logic               clamp_f;
  logic signed [PW-1:0] prod_r [0:5];
  logic signed [PW-1:0] prod_nxt [0:5];
  logic signed [31:0] off_r [0:2];
  urmg_pkg::side_t    side1_r, side1_nxt, side2_r;
  logic               vld1_r, vld2_r;
  logic signed [SW-1:0] nx_r, ny_r, dn_r;

  logic               div_vld;
  logic signed [31:0] div_xn, div_yn;
  urmg_pkg::side_t    div_side;

  // Handshake: every stage moves unless a finished word is held.
  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r  <= 24'd204800;
      focal_y_r  <= 24'd204800;
      center_x_r <= 24'd163840;
      center_y_r <= 24'd92160;
      k1_r       <= '0;
      k2_r       <= '0;
      k3_r       <= '0;
    end else if (cfg_we) begin
      unique case (urmg_pkg::cfg_reg_t'(cfg_index))
        urmg_pkg::REG_FOCAL_X:  focal_x_r  <= cfg_wdata[23:0];
        urmg_pkg::REG_FOCAL_Y:  focal_y_r  <= cfg_wdata[23:0];
        urmg_pkg::REG_CENTER_X: center_x_r <= cfg_wdata[23:0];
        urmg_pkg::REG_CENTER_Y: center_y_r <= cfg_wdata[23:0];
        urmg_pkg::REG_K1:       k1_r       <= $signed(cfg_wdata);
        urmg_pkg::REG_K2:       k2_r       <= $signed(cfg_wdata);
        urmg_pkg::REG_K3:       k3_r       <= $signed(cfg_wdata);
        // The reserved register has no effect on the mapping.
        urmg_pkg::REG_RESERVED: ;
      endcase
    end
  end

  // Coefficient store, written by mode 0 words in stream order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < urmg_pkg::STORE_WORDS; i++) begin
        coef_r[i] <= '0;
      end
    end else if (in_acc && in_ch.mode == urmg_pkg::MODE_COEF &&
                 32'(in_ch.word_index) < urmg_pkg::STORE_WORDS) begin
      coef_r[in_ch.word_index] <= in_ch.word_value;
    end
  end

  // Stage 1: clamp the pixel and form the six matrix products.
  always_comb begin
    logic signed [12:0] us, vs;
    clamp_f = 1'b0;
    col_c   = in_ch.pixel_col;
    row_c   = in_ch.pixel_row;
    if (32'(in_ch.pixel_col) >= urmg_pkg::MAX_DIM) begin
      col_c   = 12'(urmg_pkg::MAX_DIM - 1);
      clamp_f = 1'b1;
    end
    if (32'(in_ch.pixel_row) >= urmg_pkg::MAX_DIM) begin
      row_c   = 12'(urmg_pkg::MAX_DIM - 1);
      clamp_f = 1'b1;
    end
    us = $signed({1'b0, col_c});
    vs = $signed({1'b0, row_c});
    prod_nxt[0] = us * coef_r[0];
    prod_nxt[1] = vs * coef_r[1];
    prod_nxt[2] = us * coef_r[3];
    prod_nxt[3] = vs * coef_r[4];
    prod_nxt[4] = us * coef_r[6];
    prod_nxt[5] = vs * coef_r[7];
    side1_nxt.m9   = coef_r[9];
    side1_nxt.m10  = coef_r[10];
    side1_nxt.zero = 1'b0;
    side1_nxt.flag = clamp_f;
  end

  // Front pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (adv) begin
      vld1_r <= in_acc && in_ch.mode == urmg_pkg::MODE_PIXEL;
      vld2_r <= vld1_r;
    end
  end

  // Front pipeline payload; stage 2 sums the products into x, y and w.
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r   <= prod_nxt;
      off_r[0] <= coef_r[2];
      off_r[1] <= coef_r[5];
      off_r[2] <= coef_r[8];
      side1_r  <= side1_nxt;
      nx_r     <= SW'(prod_r[0]) + SW'(prod_r[1]) + SW'(off_r[0]);
      ny_r     <= SW'(prod_r[2]) + SW'(prod_r[3]) + SW'(off_r[1]);
      dn_r     <= SW'(prod_r[4]) + SW'(prod_r[5]) + SW'(off_r[2]);
      side2_r  <= side1_r;
    end
  end

  urmg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (vld2_r),
    .num_x    (nx_r),
    .num_y    (ny_r),
    .den      (dn_r),
    .side_in  (side2_r),
    .out_vld  (div_vld),
    .xn       (div_xn),
    .yn       (div_yn),
    .side_out (div_side)
  );

  urmg_dist u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (div_vld),
    .xn       (div_xn),
    .yn       (div_yn),
    .side     (div_side),
    .k1       (k1_r),
    .k2       (k2_r),
    .k3       (k3_r),
    .focal_x  (focal_x_r),
    .focal_y  (focal_y_r),
    .center_x (center_x_r),
    .center_y (center_y_r),
    .out_vld  (dist_vld),
    .map_x    (out_ch.map_x),
    .map_y    (out_ch.map_y),
    .sat      (out_ch.saturated)
  );

  assign out_ch.valid = dist_vld;

endmodule
